### rtl/core/artl_pkg.sv
// artl_pkg: shared constants, types and codes for the address range table.
// Used by the controller, datapath and top level of address_range_table_lookup.
package artl_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned IdxBits  = $clog2(Capacity);
  localparam int unsigned CntBits  = $clog2(Capacity + 1);
  localparam int unsigned AddrBits = 64;
  localparam int unsigned TagBits  = 16;

  typedef logic [IdxBits-1:0]  idx_t;
  typedef logic [CntBits-1:0]  cnt_t;
  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [TagBits-1:0]  tag_t;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdAdd    = 2'd1,
    CmdSort   = 2'd2,
    CmdLookup = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StMiss  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SLkRead,   // decode captured request, start command
    SLkWait,   // issue probe read of mid, or of candidate lo-1
    SLkFinal,  // compare candidate entry lo-1
    SLkCheck,
    SSrtRead,  // read entry i into hold
    SSrtHold,
    SSrtCmp,   // read j-1
    SSrtTest,
    SSrtPut,   // write hold at j
    SOut
  } state_e;

  // Controller -> datapath commands.
  typedef struct packed {
    logic    load_req;     // capture request fields
    logic    do_clear;
    logic    do_add;
    logic    lk_init;
    logic    lk_read_mid;
    logic    lk_step;
    logic    lk_read_cand;
    logic    lk_check;
    logic    srt_init;
    logic    srt_read_i;
    logic    srt_hold;
    logic    srt_read_prev;
    logic    srt_shift;    // copy j-1 to j, j--
    logic    srt_put;      // write hold at j, i++
    status_e add_status;
  } ctrl_t;

  // Datapath -> controller status.
  typedef struct packed {
    cmd_e    cmd;
    logic    range_empty;
    logic    table_full;
    logic    lk_done;      // lo >= hi
    logic    lk_has_cand;  // lo > 0
    logic    srt_done;     // i >= count
    logic    srt_j_zero;
    logic    srt_move;     // low[j-1] > hold low
  } stat_t;

endpackage

### rtl/core/artl_datapath.sv
// artl_datapath: entry memories, search/sort index registers and result register.
// Depends on artl_pkg; driven by artl_controller commands.
module artl_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  artl_pkg::ctrl_t      ctrl_i,
  input  logic [2*artl_pkg::AddrBits+artl_pkg::TagBits+1:0] req_i,
  input  artl_pkg::addr_t      query_i,
  output artl_pkg::stat_t      stat_o,
  output artl_pkg::status_e    status_o,
  output logic                 hit_o,
  output artl_pkg::tag_t       hit_tag_o,
  output artl_pkg::cnt_t       entries_o
);

  // Entry memories, one read port with registered data, one write port.
  logic [2*artl_pkg::AddrBits+artl_pkg::TagBits-1:0] mem_q [artl_pkg::Capacity];
  logic [2*artl_pkg::AddrBits+artl_pkg::TagBits-1:0] rd_q, hold_q, wr_data;
  artl_pkg::idx_t rd_addr, wr_addr;
  logic           rd_en, wr_en;

  artl_pkg::cmd_e  cmd_q;
  artl_pkg::addr_t lo_a_q, hi_a_q, query_q;
  artl_pkg::tag_t  tag_q;
  artl_pkg::cnt_t  count_q, lo_q, hi_q, mid, i_q, j_q;
  artl_pkg::status_e status_q;
  logic            hit_q;
  artl_pkg::tag_t  hit_tag_q;

  artl_pkg::addr_t rd_low, rd_high, hold_low;
  assign rd_low   = rd_q[2*artl_pkg::AddrBits+artl_pkg::TagBits-1 -: artl_pkg::AddrBits];
  assign rd_high  = rd_q[artl_pkg::AddrBits+artl_pkg::TagBits-1 -: artl_pkg::AddrBits];
  assign hold_low = hold_q[2*artl_pkg::AddrBits+artl_pkg::TagBits-1 -: artl_pkg::AddrBits];

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // Memory address and write selection.
  always_comb begin
    cnt_pkg_rd:
    begin
      artl_pkg::cnt_t a;
      a = i_q;
      rd_en = 1'b0;
      if (ctrl_i.lk_read_mid) begin
        a = mid; rd_en = 1'b1;
      end else if (ctrl_i.lk_read_cand) begin
        a = lo_q - 1'b1; rd_en = 1'b1;
      end else if (ctrl_i.srt_read_i) begin
        a = i_q; rd_en = 1'b1;
      end else if (ctrl_i.srt_read_prev) begin
        a = j_q - 1'b1; rd_en = 1'b1;
      end
      rd_addr = a[artl_pkg::IdxBits-1:0];
    end
    wr_en   = 1'b0;
    wr_addr = j_q[artl_pkg::IdxBits-1:0];
    wr_data = hold_q;
    if (ctrl_i.do_add) begin
      wr_en   = 1'b1;
      wr_addr = count_q[artl_pkg::IdxBits-1:0];
      wr_data = {lo_a_q, hi_a_q, tag_q};
    end else if (ctrl_i.srt_shift) begin
      wr_en   = 1'b1;
      wr_data = rd_q;
    end else if (ctrl_i.srt_put) begin
      wr_en   = 1'b1;
    end
  end

  // Memory ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
    if (ctrl_i.srt_hold) hold_q <= rd_q;
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_req) begin
      cmd_q   <= artl_pkg::cmd_e'(req_i[1:0]);
      lo_a_q  <= req_i[2 +: artl_pkg::AddrBits];
      hi_a_q  <= req_i[2+artl_pkg::AddrBits +: artl_pkg::AddrBits];
      tag_q   <= req_i[2+2*artl_pkg::AddrBits +: artl_pkg::TagBits];
      query_q <= query_i;
    end
  end

  // Count, search and sort indexes, result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      i_q       <= '0;
      j_q       <= '0;
      status_q  <= artl_pkg::StOk;
      hit_q     <= 1'b0;
      hit_tag_q <= '0;
    end else begin
      if (ctrl_i.load_req) begin
        status_q  <= artl_pkg::StOk;
        hit_q     <= 1'b0;
        hit_tag_q <= '0;
      end
      if (ctrl_i.do_clear) count_q <= '0;
      if (ctrl_i.do_add) count_q <= count_q + 1'b1;
      if (ctrl_i.add_status != artl_pkg::StOk) status_q <= ctrl_i.add_status;
      if (ctrl_i.lk_init) begin
        lo_q <= '0;
        hi_q <= count_q;
      end
      if (ctrl_i.lk_step) begin
        if (rd_low <= query_q) lo_q <= mid + 1'b1;
        else                   hi_q <= mid;
      end
      if (ctrl_i.lk_init) status_q <= artl_pkg::StMiss;
      if (ctrl_i.lk_check && query_q >= rd_low && query_q < rd_high) begin
        status_q  <= artl_pkg::StOk;
        hit_q     <= 1'b1;
        hit_tag_q <= rd_q[artl_pkg::TagBits-1:0];
      end
      if (ctrl_i.srt_init) i_q <= artl_pkg::cnt_t'(1);
      if (ctrl_i.srt_hold) j_q <= i_q;
      if (ctrl_i.srt_shift) j_q <= j_q - 1'b1;
      if (ctrl_i.srt_put) i_q <= i_q + 1'b1;
    end
  end

  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.range_empty = hi_a_q <= lo_a_q;
    stat_o.table_full  = count_q >= artl_pkg::cnt_t'(artl_pkg::Capacity);
    stat_o.lk_done     = lo_q >= hi_q;
    stat_o.lk_has_cand = lo_q != '0;
    stat_o.srt_done    = i_q >= count_q;
    stat_o.srt_j_zero  = j_q == '0;
    stat_o.srt_move    = rd_low > hold_low;
  end

  assign status_o  = status_q;
  assign hit_o     = hit_q;
  assign hit_tag_o = hit_tag_q;
  assign entries_o = count_q;

  // Search window is non-empty at each probe, count stays within capacity, tag is zero without a hit.
  a_lo_le_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.lk_step |-> lo_q < hi_q) else $error("probe with empty window");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= artl_pkg::cnt_t'(artl_pkg::Capacity)) else $error("count over capacity");
  a_hit_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hit_q |-> hit_tag_q == '0) else $error("tag without hit");

endmodule

### rtl/core/artl_controller.sv
// artl_controller: state machine sequencing clear, add, binary search and insertion sort.
// Depends on artl_pkg; commands artl_datapath.
module artl_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  artl_pkg::stat_t  stat_i,
  output artl_pkg::ctrl_t  ctrl_o
);

  artl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= artl_pkg::SIdle;
    else         state_q <= state_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      artl_pkg::SIdle: if (in_valid_i) begin
        state_d = artl_pkg::SLkRead; // dispatch resolved next cycle
      end
      artl_pkg::SLkRead: begin
        // state after accept: decode the captured request
        unique case (stat_i.cmd)
          artl_pkg::CmdClear, artl_pkg::CmdAdd: state_d = artl_pkg::SOut;
          artl_pkg::CmdSort:   state_d = artl_pkg::SSrtRead;
          artl_pkg::CmdLookup: state_d = artl_pkg::SLkWait;
        endcase
      end
      artl_pkg::SLkWait:
        if (stat_i.lk_done) state_d = stat_i.lk_has_cand ? artl_pkg::SLkFinal : artl_pkg::SOut;
        else                state_d = artl_pkg::SLkCheck;
      artl_pkg::SLkCheck: state_d = artl_pkg::SLkWait;  // probe step done
      artl_pkg::SLkFinal: state_d = artl_pkg::SOut;     // compare candidate
      artl_pkg::SSrtRead:
        state_d = stat_i.srt_done ? artl_pkg::SOut : artl_pkg::SSrtHold;
      artl_pkg::SSrtHold: state_d = artl_pkg::SSrtCmp;
      artl_pkg::SSrtCmp:
        state_d = stat_i.srt_j_zero ? artl_pkg::SSrtPut : artl_pkg::SSrtTest;
      artl_pkg::SSrtTest:
        state_d = stat_i.srt_move ? artl_pkg::SSrtCmp : artl_pkg::SSrtPut;
      artl_pkg::SSrtPut: state_d = artl_pkg::SSrtRead;
      artl_pkg::SOut: if (out_ready_i) state_d = artl_pkg::SIdle;
      default: state_d = artl_pkg::SIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl_o      = '0;
    ctrl_o.add_status = artl_pkg::StOk;
    in_ready_o  = state_q == artl_pkg::SIdle;
    out_valid_o = state_q == artl_pkg::SOut;
    unique case (state_q)
      artl_pkg::SIdle: ctrl_o.load_req = in_valid_i;
      artl_pkg::SLkRead: begin
        unique case (stat_i.cmd)
          artl_pkg::CmdClear: ctrl_o.do_clear = 1'b1;
          artl_pkg::CmdAdd:
            if (stat_i.range_empty)     ctrl_o.add_status = artl_pkg::StEmpty;
            else if (stat_i.table_full) ctrl_o.add_status = artl_pkg::StFull;
            else                        ctrl_o.do_add = 1'b1;
          artl_pkg::CmdSort:   ctrl_o.srt_init = 1'b1;
          artl_pkg::CmdLookup: ctrl_o.lk_init = 1'b1;
        endcase
      end
      artl_pkg::SLkWait:
        if (!stat_i.lk_done) ctrl_o.lk_read_mid = 1'b1;
        else if (stat_i.lk_has_cand) ctrl_o.lk_read_cand = 1'b1;
      artl_pkg::SLkCheck: ctrl_o.lk_step = 1'b1;
      artl_pkg::SLkFinal: ctrl_o.lk_check = 1'b1;
      artl_pkg::SSrtRead: ctrl_o.srt_read_i = !stat_i.srt_done;
      artl_pkg::SSrtHold: ctrl_o.srt_hold = 1'b1;
      artl_pkg::SSrtCmp:  ctrl_o.srt_read_prev = !stat_i.srt_j_zero;
      artl_pkg::SSrtTest: ctrl_o.srt_shift = stat_i.srt_move;
      artl_pkg::SSrtPut:  ctrl_o.srt_put = 1'b1;
      default: ;
    endcase
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.do_add && ctrl_o.srt_shift)) else $error("two writes");

endmodule

### rtl/core/address_range_table_lookup.sv
// address_range_table_lookup: top level joining controller and datapath.
// Depends on artl_pkg, artl_controller, artl_datapath.
//
//  channel  | dir | tdata (low bit up)                                  | tuser
//  s_axis   | in  | range_low[63:0], range_high[63:0], range_tag[15:0], | cmd[1:0]
//           |     | query_address[63:0]                                 |
//  m_axis   | out | hit_tag[15:0], entries_held[8:0], pad               | status[1:0], hit
//
// One request at a time. Lookup: binary search, one memory read per probe. Sort:
// insertion sort over the one read port. Reset clears the entry count, the search and
// sort indexes and the result, not the entry memories; results hold until taken on m_axis.
module address_range_table_lookup (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [207:0]  s_axis_tdata,  // range_low, range_high, range_tag, query_address
  input  logic [1:0]    s_axis_tuser,  // cmd
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata,  // hit_tag, entries_held
  output logic [2:0]    m_axis_tuser   // status, hit
);

  artl_pkg::ctrl_t   ctrl;
  artl_pkg::stat_t   stat;
  artl_pkg::status_e status;
  logic              hit;
  artl_pkg::tag_t    hit_tag;
  artl_pkg::cnt_t    entries;

  artl_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  artl_datapath u_dp (
    .clk_i, .rst_ni,
    .ctrl_i   (ctrl),
    .req_i    ({s_axis_tdata[143:0], s_axis_tuser}),
    .query_i  (s_axis_tdata[207:144]),
    .stat_o   (stat),
    .status_o (status),
    .hit_o    (hit),
    .hit_tag_o(hit_tag),
    .entries_o(entries)
  );

  assign m_axis_tdata = {7'd0, entries, hit_tag};
  assign m_axis_tuser = {hit, status};

endmodule

### tb/testbench.sv
// testbench: self-checking bench for address_range_table_lookup (range table with binary search).
// Depends on artl_pkg and the RTL top level; holds its own predictor of the range table.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned     CycleLimit = 3000000;
  localparam artl_pkg::addr_t AddrMax    = {artl_pkg::AddrBits{1'b1}};

  typedef struct {
    artl_pkg::cmd_e  cmd;
    artl_pkg::addr_t lo;
    artl_pkg::addr_t hi;
    artl_pkg::tag_t  tag;
    artl_pkg::addr_t query;
  } request_t;

  typedef struct {
    artl_pkg::status_e status;
    logic              hit;
    artl_pkg::tag_t    tag;
    artl_pkg::cnt_t    held;
  } answer_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata;  // range_low, range_high, range_tag, query_address
  logic [1:0]   s_axis_tuser;  // cmd
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;  // hit_tag, entries_held, pad
  logic [2:0]   m_axis_tuser;  // status, hit

  address_range_table_lookup dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Predicted table contents
  artl_pkg::addr_t tbl_low  [artl_pkg::Capacity];
  artl_pkg::addr_t tbl_high [artl_pkg::Capacity];
  artl_pkg::tag_t  tbl_tag  [artl_pkg::Capacity];
  int unsigned tbl_count;

  answer_t pending_answers[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned hold_off_cycles;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Stable insertion sort by low address
  task automatic sort_table();
    artl_pkg::addr_t lo, hi;
    artl_pkg::tag_t  tg;
    int    j;
    for (int i = 1; i < tbl_count; i++) begin
      lo = tbl_low[i];
      hi = tbl_high[i];
      tg = tbl_tag[i];
      j  = i;
      while (j > 0 && tbl_low[j-1] > lo) begin
        tbl_low[j]  = tbl_low[j-1];
        tbl_high[j] = tbl_high[j-1];
        tbl_tag[j]  = tbl_tag[j-1];
        j--;
      end
      tbl_low[j]  = lo;
      tbl_high[j] = hi;
      tbl_tag[j]  = tg;
    end
  endtask

  // Update table and work out the answer for one accepted request
  task automatic predict_answer(input request_t r);
    answer_t a;
    int unsigned lo, hi, mid;
    a.status = artl_pkg::StOk;
    a.hit    = 1'b0;
    a.tag    = '0;
    case (r.cmd)
      artl_pkg::CmdClear: tbl_count = 0;
      artl_pkg::CmdAdd: begin
        if (r.hi <= r.lo) a.status = artl_pkg::StEmpty;
        else if (tbl_count >= artl_pkg::Capacity) a.status = artl_pkg::StFull;
        else begin
          tbl_low[tbl_count]  = r.lo;
          tbl_high[tbl_count] = r.hi;
          tbl_tag[tbl_count]  = r.tag;
          tbl_count++;
        end
      end
      artl_pkg::CmdSort: if (tbl_count >= 2) sort_table();
      default: begin
        lo = 0;
        hi = tbl_count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (tbl_low[mid] <= r.query) lo = mid + 1;
          else hi = mid;
        end
        a.status = artl_pkg::StMiss;
        if (lo > 0 && r.query >= tbl_low[lo-1] && r.query < tbl_high[lo-1]) begin
          a.status = artl_pkg::StOk;
          a.hit    = 1'b1;
          a.tag    = tbl_tag[lo-1];
        end
      end
    endcase
    a.held = artl_pkg::cnt_t'(tbl_count);
    pending_answers.push_back(a);
  endtask

  // Offer one request in bursts with random gaps; predict on acceptance
  task automatic send_request(input request_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.query, r.tag, r.hi, r.lo};
    s_axis_tuser  <= r.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_answer(r);
  endtask

  // Stop offering and wait until every answer has come back
  task automatic drain_answers();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  function automatic request_t make_request(artl_pkg::cmd_e c, artl_pkg::addr_t lo,
                                            artl_pkg::addr_t hi, artl_pkg::tag_t tg,
                                            artl_pkg::addr_t q);
    request_t r;
    r.cmd   = c;
    r.lo    = lo;
    r.hi    = hi;
    r.tag   = tg;
    r.query = q;
    return r;
  endfunction

  function automatic artl_pkg::addr_t rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Random filler for fields that a command does not use
  function automatic request_t noisy(artl_pkg::cmd_e c);
    return make_request(c, rand_addr(), rand_addr(), artl_pkg::tag_t'($urandom), rand_addr());
  endfunction

  function automatic request_t add_req(artl_pkg::addr_t lo, artl_pkg::addr_t hi,
                                       artl_pkg::tag_t tg);
    request_t r;
    r    = noisy(artl_pkg::CmdAdd);
    r.lo = lo;
    r.hi = hi;
    r.tag = tg;
    return r;
  endfunction

  function automatic request_t lookup_req(artl_pkg::addr_t q);
    request_t r;
    r       = noisy(artl_pkg::CmdLookup);
    r.query = q;
    return r;
  endfunction

  // Edges of the address space and the special cases
  task automatic test_directed();
    send_request(lookup_req('0));                       // empty table
    send_request(noisy(artl_pkg::CmdSort));             // sort of nothing
    send_request(add_req(64'd100, 64'd100, 16'h1111));  // empty range
    send_request(add_req(64'd200, 64'd100, 16'h2222));  // inverted range
    send_request(add_req(AddrMax - 1, AddrMax, 16'hFFFF));
    send_request(noisy(artl_pkg::CmdSort));             // single entry
    send_request(lookup_req(AddrMax - 1));
    send_request(lookup_req(AddrMax));                  // high is exclusive
    send_request(add_req(64'd0, 64'd10, 16'h0000));
    send_request(add_req(64'd5, 64'd50, 16'hA5A5));     // overlaps previous
    send_request(add_req(64'd5, 64'd7, 16'h5A5A));      // equal low, later arrival
    send_request(lookup_req(64'd6));                    // unsorted search
    send_request(noisy(artl_pkg::CmdSort));
    send_request(lookup_req(64'd0));
    send_request(lookup_req(64'd6));                    // stable order decides
    send_request(lookup_req(64'd20));                   // overlap, selected entry misses
    send_request(lookup_req(64'd4));
    send_request(add_req(64'd1000, AddrMax, 16'h8001));
    send_request(noisy(artl_pkg::CmdSort));
    send_request(lookup_req(AddrMax));
    send_request(lookup_req(64'd999));
    send_request(noisy(artl_pkg::CmdClear));
    send_request(lookup_req(64'd6));
    drain_answers();
  endtask

  // Fill to capacity, overflow, sort the full table
  task automatic test_full_table();
    artl_pkg::addr_t lo;
    send_request(noisy(artl_pkg::CmdClear));
    for (int i = 0; i < artl_pkg::Capacity; i++) begin
      lo = rand_addr() >> $urandom_range(0, 8);
      send_request(add_req(lo, lo + $urandom_range(1, 1 << 20), artl_pkg::tag_t'($urandom)));
    end
    send_request(add_req(64'd1, 64'd2, 16'h1234));      // full: dropped
    send_request(add_req(64'd9, 64'd3, 16'h4321));      // empty wins over full
    send_request(lookup_req(tbl_low[7]));               // unsorted full table
    send_request(noisy(artl_pkg::CmdSort));
    for (int i = 0; i < 8; i++)
      send_request(lookup_req(tbl_low[$urandom_range(0, artl_pkg::Capacity - 1)]
                              + $urandom_range(0, 3)));
    send_request(noisy(artl_pkg::CmdClear));
    drain_answers();
  endtask

  // Well-formed sequences with random content, plus noise
  task automatic test_random(input int unsigned items);
    int unsigned sent, n, k, sel;
    artl_pkg::addr_t base, lo, q;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any command with random fields
        send_request(noisy(artl_pkg::cmd_e'($urandom_range(0, 3))));
        sent++;
        continue;
      end
      if (tbl_count > 24 || $urandom_range(0, 2) != 0) begin
        send_request(noisy(artl_pkg::CmdClear));
        sent++;
      end
      base = ($urandom_range(0, 3) == 0) ? rand_addr()
                                          : artl_pkg::addr_t'($urandom_range(0, 4096));
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(0, 9);
        lo  = (sel < 2) ? rand_addr() : base + $urandom_range(0, 512);
        if (sel == 9)
          send_request(add_req(lo, lo - $urandom_range(0, 3), artl_pkg::tag_t'($urandom)));
        else if (sel == 8)
          send_request(add_req(lo, AddrMax, artl_pkg::tag_t'($urandom)));
        else
          send_request(add_req(lo, lo + $urandom_range(1, 200), artl_pkg::tag_t'($urandom)));
        sent++;
      end
      if ($urandom_range(0, 4) != 0) begin
        send_request(noisy(artl_pkg::CmdSort));
        sent++;
      end
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        if (tbl_count > 0 && $urandom_range(0, 4) != 0) begin
          k = $urandom_range(0, tbl_count - 1);
          case ($urandom_range(0, 4))
            0: q = tbl_low[k];
            1: q = tbl_high[k] - 1;
            2: q = tbl_high[k];
            3: q = tbl_low[k] - 1;
            default: q = tbl_low[k] + $urandom_range(0, 255);
          endcase
        end else begin
          q = rand_addr();
        end
        send_request(lookup_req(q));
        sent++;
      end
    end
    drain_answers();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off_cycles = 400;
    for (int i = 0; i < 12; i++)
      send_request(lookup_req(tbl_count > 0 ? tbl_low[0] : rand_addr()));
    drain_answers();
  endtask

  // Receiver stall pattern, with a counted long hold-off on request
  logic stall_mode;
  int unsigned mode_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 1'b0;
      mode_left     <= 0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready   <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= ~stall_mode;
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      m_axis_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  // Compare each answer with the oldest prediction
  always @(posedge clk_i) begin
    answer_t exp_a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer tdata=%h tuser=%h", $time, m_axis_tdata,
                 m_axis_tuser);
        error_count++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (m_axis_tuser[1:0] !== exp_a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_a.status,
                   m_axis_tuser[1:0]);
          error_count++;
        end
        if (m_axis_tuser[2] !== exp_a.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_a.hit, m_axis_tuser[2]);
          error_count++;
        end
        if (m_axis_tdata[15:0] !== exp_a.tag) begin
          $display("%0t: hit_tag expected %h actual %h", $time, exp_a.tag,
                   m_axis_tdata[15:0]);
          error_count++;
        end
        if (m_axis_tdata[24:16] !== exp_a.held) begin
          $display("%0t: entries_held expected %0d actual %0d", $time, exp_a.held,
                   m_axis_tdata[24:16]);
          error_count++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    error_count     = 0;
    cycle_count     = 0;
    burst_left      = 0;
    hold_off_cycles = 0;
    tbl_count       = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    test_random(220);
    test_backpressure();
    test_random(220);

    drain_answers();
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && pending_answers.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
